/* rtl/rgbc_pkg.sv */
// Shared types, constants and arithmetic helpers for the RGB 3x3 convolution filter.
package rgbc_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int CH_W       = 8;
    localparam int CH_NUM     = 3;
    localparam int PIX_W      = CH_W * CH_NUM;
    localparam int TAP_NUM    = 9;
    localparam int KER_DIM    = 3;
    localparam int COEF_W     = 12;
    localparam int COEF_ROW_W = COEF_W * KER_DIM;
    localparam int PROD_W     = COEF_W + CH_W;
    localparam int SUM_W      = PROD_W + 4;
    localparam int FRAC_BITS  = 4;
    localparam int CH_MAX     = 255;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = COEF_ROW_W;
    localparam int CFG_DIM_W  = 11;

    localparam int RST_FRAME_WIDTH  = 500;
    localparam int RST_FRAME_HEIGHT = 250;
    localparam logic [COEF_ROW_W-1:0] RST_COEF_TOP    = 36'h0;
    localparam logic [COEF_ROW_W-1:0] RST_COEF_MID    = 36'h0_0001_0000;
    localparam logic [COEF_ROW_W-1:0] RST_COEF_BOTTOM = 36'h0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 3'd0,
        CFG_FRAME_HEIGHT = 3'd1,
        CFG_COEF_TOP     = 3'd2,
        CFG_COEF_MID     = 3'd3,
        CFG_COEF_BOTTOM  = 3'd4
    } cfg_reg_e;

    typedef logic [PIX_W-1:0]      pixel_t;
    typedef logic [COEF_ROW_W-1:0] coef_row_t;
    typedef coef_row_t [KER_DIM-1:0] coef_rows_t;

    typedef struct packed {
        pixel_t [TAP_NUM-1:0] taps;
        logic                 last;
    } tap_word_t;

    function automatic logic signed [PROD_W-1:0] mul_tap(
        input logic signed [COEF_W-1:0] coef,
        input logic [CH_W-1:0]          px
    );
        logic signed [CH_W:0] px_s;
        px_s = {1'b0, px};
        return coef * px_s;
    endfunction

    function automatic logic [CH_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] sum);
        logic signed [SUM_W-1:0] v;
        v = sum >>> FRAC_BITS;
        if (sum < 0) begin
            return '0;
        end else if (v > CH_MAX) begin
            return CH_W'(CH_MAX);
        end else begin
            return v[CH_W-1:0];
        end
    endfunction

endpackage

/* rtl/rgbc_mac.sv */
// Multiply-accumulate pipeline: nine taps times kernel, sum, shift, clamp, output register.
module rgbc_mac (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   tap_valid,
    output logic                   tap_ready,
    input  rgbc_pkg::tap_word_t    tap_word,
    input  rgbc_pkg::coef_rows_t   coef_rows,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [23:0]            m_tdata,   // red_out, green_out, blue_out
    output logic                   m_tlast    // frame_last
);
    import rgbc_pkg::*;

    logic                      s2_valid_reg, s3_valid_reg, s4_valid_reg, out_valid_reg;
    logic                      s2_last_reg, s3_last_reg, s4_last_reg, out_last_reg;
    pixel_t [TAP_NUM-1:0]      s2_taps_reg;
    logic signed [PROD_W-1:0]  prod_reg [CH_NUM][TAP_NUM];
    logic signed [SUM_W-1:0]   psum_reg [CH_NUM][KER_DIM];
    logic [PIX_W-1:0]          out_data_reg;
    logic [PIX_W-1:0]          out_data_next;
    logic signed [SUM_W-1:0]   total [CH_NUM];
    logic                      out_free, s4_free, s3_free, s2_free;

    assign out_free  = !out_valid_reg || m_tready;
    assign s4_free   = !s4_valid_reg || out_free;
    assign s3_free   = !s3_valid_reg || s4_free;
    assign s2_free   = !s2_valid_reg || s3_free;
    assign tap_ready = s2_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s2_free) begin
                s2_valid_reg <= tap_valid;
            end
            if (s3_free) begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_free) begin
                s4_valid_reg <= s3_valid_reg;
            end
            if (out_free) begin
                out_valid_reg <= s4_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_free && tap_valid) begin
            s2_taps_reg <= tap_word.taps;
            s2_last_reg <= tap_word.last;
        end
        if (s3_free && s2_valid_reg) begin
            s3_last_reg <= s2_last_reg;
        end
        if (s4_free && s3_valid_reg) begin
            s4_last_reg <= s3_last_reg;
        end
        if (out_free && s4_valid_reg) begin
            out_last_reg <= s4_last_reg;
            out_data_reg <= out_data_next;
        end
    end

    // tap row k is the oldest row first, so it meets kernel row 2-k (true convolution)
    for (genvar ch = 0; ch < CH_NUM; ch++) begin : g_ch
        for (genvar k = 0; k < KER_DIM; k++) begin : g_row
            for (genvar j = 0; j < KER_DIM; j++) begin : g_col
                always_ff @(posedge aclk) begin
                    if (s3_free && s2_valid_reg) begin
                        prod_reg[ch][k*KER_DIM+j] <= mul_tap(
                            coef_rows[KER_DIM-1-k][COEF_W*(KER_DIM-1-j) +: COEF_W],
                            s2_taps_reg[k*KER_DIM+j][CH_W*ch +: CH_W]);
                    end
                end
            end
            always_ff @(posedge aclk) begin
                if (s4_free && s3_valid_reg) begin
                    psum_reg[ch][k] <= prod_reg[ch][k*KER_DIM]
                                     + prod_reg[ch][k*KER_DIM+1]
                                     + prod_reg[ch][k*KER_DIM+2];
                end
            end
        end
        assign total[ch] = psum_reg[ch][0] + psum_reg[ch][1] + psum_reg[ch][2];
        assign out_data_next[CH_W*ch +: CH_W] = clamp_channel(total[ch]);
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    a_tap_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_valid && tap_ready |=> s2_valid_reg)
        else $error("accepted tap word did not enter the multiply stage");

    a_sum_reaches_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s4_valid_reg && out_free |=> m_tvalid)
        else $error("finished sum was not presented on the output");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !s2_valid_reg && !s3_valid_reg && !s4_valid_reg |-> tap_ready)
        else $error("empty pipeline refused a tap word");

endmodule

/* rtl/rgb_3x3_convolution_filter.sv */
// Top level of the RGB 3x3 convolution filter: config, position counters, line stores, window.
//
// Streaming 3x3 convolution on RGB pixels in raster order. The block takes one pixel per
// clock unless the output stalls, with no gaps between rows or frames. Each accepted word
// reads both line stores at its column and writes them back, through one read and one write
// port per store; a column hit by two words in a row (frame width 1, or the first word of a
// frame right after the last word of the one before, both at column 0) is served by a bypass
// register. The result for pixel (y,x) comes out with the word for (y+1,x+1), five register
// stages after that word is accepted; after a frame send frame_width+1 flush words (tuser set)
// to drain the tail. The last result of a frame carries tlast. Kernel rows are three signed
// Q8.4 coefficients each; sums are shifted right by 4 and clamped to 0..255. Line stores are
// not cleared after reset and need no clearing pass; out-of-image neighbors read as zero.
// Width and height are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT when written.
module rgb_3x3_convolution_filter #(
    parameter int MAX_WIDTH  = rgbc_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = rgbc_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [rgbc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rgbc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [23:0]                     s_tdata,   // red_in, green_in, blue_in
    input  logic                            s_tuser,   // flush
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,   // red_out, green_out, blue_out
    output logic                            m_tlast    // frame_last
);
    import rgbc_pkg::*;

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W = $clog2(MAX_WIDTH + 1);
    localparam int HCNT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 3);
    localparam int POS_W  = ((ROW_W > HCNT_W) ? ROW_W : HCNT_W) + 2;
    localparam int W_RST  = (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
    localparam int H_RST  = (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;

    // config
    logic [WCNT_W-1:0]    frame_w_reg;
    logic [HCNT_W-1:0]    frame_h_reg;
    coef_rows_t           coef_rows_reg;
    logic [CFG_DIM_W-1:0] cfg_dim;
    logic [WCNT_W-1:0]    w_clamped;
    logic [HCNT_W-1:0]    h_clamped;

    // position
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 col_wrap;
    logic [COL_W-1:0]     acc_col;
    logic [ROW_W-1:0]     acc_row;
    logic [WCNT_W-1:0]    acc_col_inc;
    logic                 acc_last, acc_emit, acc_col_zero;
    logic [KER_DIM-1:0]   row_ok, col_ok;
    logic [TAP_NUM-1:0]   acc_mask;
    logic [POS_W-1:0]     row_off;
    logic                 in_accept;

    // memory stage
    logic                 p1_valid_reg, p1_emit_reg, p1_last_reg, p1_fwd_reg;
    logic [COL_W-1:0]     p1_col_reg;
    pixel_t               p1_cur_reg, p1_fwd_a_reg, p1_fwd_b_reg;
    logic [TAP_NUM-1:0]   p1_mask_reg;
    pixel_t               a_rd_reg, b_rd_reg;
    pixel_t               a_eff, b_eff;
    logic                 p1_leave;
    pixel_t               line_a_mem [MAX_WIDTH];
    pixel_t               line_b_mem [MAX_WIDTH];

    // window
    pixel_t               win_reg  [TAP_NUM];
    pixel_t               win_next [TAP_NUM];
    pixel_t [KER_DIM-1:0] new_col;
    tap_word_t            tap_word;
    logic                 tap_valid, tap_ready;

    assign cfg_ready = 1'b1;
    assign cfg_dim   = cfg_data[CFG_DIM_W-1:0];

    always_comb begin
        if (cfg_dim == '0) begin
            w_clamped = WCNT_W'(1);
        end else if (32'(cfg_dim) > MAX_WIDTH) begin
            w_clamped = WCNT_W'(MAX_WIDTH);
        end else begin
            w_clamped = WCNT_W'(cfg_dim);
        end
        if (cfg_dim == '0) begin
            h_clamped = HCNT_W'(1);
        end else if (32'(cfg_dim) > MAX_HEIGHT) begin
            h_clamped = HCNT_W'(MAX_HEIGHT);
        end else begin
            h_clamped = HCNT_W'(cfg_dim);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_w_reg      <= WCNT_W'(W_RST);
            frame_h_reg      <= HCNT_W'(H_RST);
            coef_rows_reg[0] <= RST_COEF_TOP;
            coef_rows_reg[1] <= RST_COEF_MID;
            coef_rows_reg[2] <= RST_COEF_BOTTOM;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                CFG_FRAME_WIDTH:  frame_w_reg      <= w_clamped;
                CFG_FRAME_HEIGHT: frame_h_reg      <= h_clamped;
                CFG_COEF_TOP:     coef_rows_reg[0] <= cfg_data;
                CFG_COEF_MID:     coef_rows_reg[1] <= cfg_data;
                CFG_COEF_BOTTOM:  coef_rows_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // position of the incoming word; a column past a shrunk width starts the next row
    assign col_wrap     = WCNT_W'(col_reg) >= frame_w_reg;
    assign acc_col      = col_wrap ? '0 : col_reg;
    assign acc_row      = col_wrap ? row_reg + ROW_W'(1) : row_reg;
    assign acc_col_zero = acc_col == '0;
    assign acc_last     = POS_W'(acc_row) > POS_W'(frame_h_reg);
    assign acc_emit     = !(acc_row == '0 || (acc_row == ROW_W'(1) && acc_col_zero));
    assign acc_col_inc  = WCNT_W'(acc_col) + WCNT_W'(1);
    assign row_off      = acc_col_zero ? POS_W'(3) : POS_W'(2);

    always_comb begin
        for (int k = 0; k < KER_DIM; k++) begin
            row_ok[k] = (POS_W'(acc_row) + POS_W'(k) >= row_off)
                     && (POS_W'(acc_row) + POS_W'(k) < POS_W'(frame_h_reg) + row_off);
        end
        if (acc_col_zero) begin
            col_ok[0] = frame_w_reg >= WCNT_W'(2);
            col_ok[1] = 1'b1;
            col_ok[2] = 1'b0;
        end else begin
            col_ok[0] = acc_col >= COL_W'(2);
            col_ok[1] = 1'b1;
            col_ok[2] = 1'b1;
        end
        for (int k = 0; k < KER_DIM; k++) begin
            for (int j = 0; j < KER_DIM; j++) begin
                acc_mask[k*KER_DIM+j] = row_ok[k] & col_ok[j];
            end
        end
    end

    always_comb begin
        if (acc_last) begin
            col_next = '0;
            row_next = '0;
        end else if (acc_col_inc >= frame_w_reg) begin
            col_next = '0;
            row_next = acc_row + ROW_W'(1);
        end else begin
            col_next = acc_col_inc[COL_W-1:0];
            row_next = acc_row;
        end
    end

    assign p1_leave  = p1_valid_reg && (!p1_emit_reg || tap_ready);
    assign s_tready  = !p1_valid_reg || p1_leave;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            p1_valid_reg <= 1'b0;
        end else begin
            if (in_accept) begin
                col_reg      <= col_next;
                row_reg      <= row_next;
                p1_valid_reg <= 1'b1;
            end else if (p1_leave) begin
                p1_valid_reg <= 1'b0;
            end
        end
    end

    // bypass: previous word writes this column at the same edge the new word reads it
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            p1_cur_reg   <= s_tuser ? '0 : s_tdata;
            p1_col_reg   <= acc_col;
            p1_emit_reg  <= acc_emit;
            p1_last_reg  <= acc_last;
            p1_mask_reg  <= acc_mask;
            p1_fwd_reg   <= p1_valid_reg && (p1_col_reg == acc_col);
            p1_fwd_a_reg <= p1_cur_reg;
            p1_fwd_b_reg <= a_eff;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_leave) begin
            line_a_mem[p1_col_reg] <= p1_cur_reg;
        end
        if (in_accept) begin
            a_rd_reg <= line_a_mem[acc_col];
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_leave) begin
            line_b_mem[p1_col_reg] <= a_eff;
        end
        if (in_accept) begin
            b_rd_reg <= line_b_mem[acc_col];
        end
    end

    assign a_eff = p1_fwd_reg ? p1_fwd_a_reg : a_rd_reg;
    assign b_eff = p1_fwd_reg ? p1_fwd_b_reg : b_rd_reg;

    assign new_col[0] = b_eff;
    assign new_col[1] = a_eff;
    assign new_col[2] = p1_cur_reg;

    always_comb begin
        for (int k = 0; k < KER_DIM; k++) begin
            win_next[k*KER_DIM]   = win_reg[k*KER_DIM+1];
            win_next[k*KER_DIM+1] = win_reg[k*KER_DIM+2];
            win_next[k*KER_DIM+2] = new_col[k];
        end
        for (int i = 0; i < TAP_NUM; i++) begin
            tap_word.taps[i] = p1_mask_reg[i] ? win_next[i] : '0;
        end
        tap_word.last = p1_last_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < TAP_NUM; i++) begin
                win_reg[i] <= '0;
            end
        end else if (p1_leave) begin
            for (int i = 0; i < TAP_NUM; i++) begin
                win_reg[i] <= win_next[i];
            end
        end
    end

    assign tap_valid = p1_valid_reg && p1_emit_reg;

    rgbc_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .tap_valid (tap_valid),
        .tap_ready (tap_ready),
        .tap_word  (tap_word),
        .coef_rows (coef_rows_reg),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    a_accept_lands: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> p1_valid_reg)
        else $error("accepted word missing from memory stage");

    a_row_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        row_reg <= ROW_W'(MAX_HEIGHT + 1))
        else $error("row counter ran past frame end");

    a_frame_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept && acc_last |=> (row_reg == '0 && col_reg == '0))
        else $error("counters not cleared after last word of frame");

endmodule
